@@ sv/bct_pkg.sv @@
// Shared types and codes of the buffer cache tag table.
package bct_pkg;

  localparam int BCT_NUM_SLOTS = 32;
  localparam int BCT_IDX_W     = 8;
  localparam int BCT_SLOT_W    = 5;
  localparam int BCT_REFS_W    = 8;
  localparam logic [BCT_REFS_W-1:0] BCT_REFS_MAX = '1;

  typedef enum logic [1:0] {
    OP_GET     = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } bct_op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_UNDER  = 2'd2
  } bct_status_t;

  typedef enum logic [1:0] {
    CMT_HIT   = 2'd0,
    CMT_CLAIM = 2'd1,
    CMT_INC   = 2'd2,
    CMT_DEC   = 2'd3
  } bct_cmt_kind_t;

  typedef struct packed {
    logic                  vld;
    bct_op_t               op;
    logic [7:0]            dev;
    logic [31:0]           blk;
    logic [BCT_SLOT_W-1:0] bslot;
    logic                  hit;
    logic [BCT_IDX_W-1:0]  hit_idx;
    logic                  hit_valid;
    logic                  free;
    logic [BCT_IDX_W-1:0]  free_idx;
    logic                  tgt_zero;
  } bct_tok_t;

  typedef struct packed {
    logic                 vld;
    bct_cmt_kind_t        kind;
    logic [BCT_IDX_W-1:0] idx;
    logic [7:0]           dev;
    logic [31:0]          blk;
  } bct_cmt_t;

endpackage

@@ sv/block_buffer_cache_tags.sv @@
// Top level of the buffer cache tag table: request launch, cell chain, decision and result.
// The token walks the cell chain one cell per cycle, and the next request waits for the
//   decision and commit.
// Reset: synchronous, active low; clears all counts, valid and assigned flags, and the
//   output valid flag. No clearing pass is needed.
module block_buffer_cache_tags #(
  parameter int NUM_SLOTS = bct_pkg::BCT_NUM_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_device,
  input  logic [31:0] in_block_number,
  input  logic [4:0]  in_buffer_slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_slot,
  output logic        out_must_read,
  output logic [1:0]  out_status
);
  import bct_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  state_t                state_r;
  bct_tok_t              launch_r;
  bct_tok_t              fin_r;
  bct_cmt_t              cmt_r;
  bct_tok_t              chain [NUM_SLOTS+1];
  logic                  out_valid_r;
  logic [BCT_SLOT_W-1:0] out_slot_r;
  logic                  out_must_read_r;
  bct_status_t           out_status_r;

  logic [BCT_SLOT_W-1:0] res_slot;
  logic                  res_rd;
  bct_status_t           res_st;
  bct_cmt_t              res_cmt;
  logic                  out_free;

  assign chain[0] = launch_r;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    bct_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .tok_i(chain[g]),
      .tok_o(chain[g+1]),
      .cmt_i(cmt_r)
    );
  end

  always_comb begin
    res_slot    = fin_r.bslot;
    res_rd      = 1'b0;
    res_st      = ST_OK;
    res_cmt     = '0;
    res_cmt.dev = fin_r.dev;
    res_cmt.blk = fin_r.blk;
    res_cmt.idx = BCT_IDX_W'(fin_r.bslot);
    unique case (fin_r.op)
      OP_GET: begin
        if (fin_r.hit) begin
          res_slot     = BCT_SLOT_W'(fin_r.hit_idx);
          res_rd       = !fin_r.hit_valid;
          res_cmt.vld  = 1'b1;
          res_cmt.kind = CMT_HIT;
          res_cmt.idx  = fin_r.hit_idx;
        end else if (fin_r.free) begin
          res_slot     = BCT_SLOT_W'(fin_r.free_idx);
          res_rd       = 1'b1;
          res_cmt.vld  = 1'b1;
          res_cmt.kind = CMT_CLAIM;
          res_cmt.idx  = fin_r.free_idx;
        end else begin
          res_slot = '0;
          res_st   = ST_NOFREE;
        end
      end
      OP_PIN: begin
        res_cmt.vld  = 1'b1;
        res_cmt.kind = CMT_INC;
      end
      OP_RELEASE, OP_UNPIN: begin
        if (fin_r.tgt_zero) begin
          res_st = ST_UNDER;
        end else begin
          res_cmt.vld  = 1'b1;
          res_cmt.kind = CMT_DEC;
        end
      end
      default: res_st = ST_OK;
    endcase
  end

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      launch_r    <= '0;
      fin_r       <= '0;
      cmt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      launch_r.vld <= (state_r == S_IDLE) && in_valid;
      if ((state_r == S_FIN) && out_free) begin
        cmt_r       <= res_cmt;
        out_valid_r <= 1'b1;
      end else begin
        cmt_r.vld <= 1'b0;
        if (out_valid_r && out_ready) begin
          out_valid_r <= 1'b0;
        end
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            launch_r.op        <= bct_op_t'(in_op);
            launch_r.dev       <= in_device;
            launch_r.blk       <= in_block_number;
            launch_r.bslot     <= in_buffer_slot;
            launch_r.hit       <= 1'b0;
            launch_r.hit_idx   <= '0;
            launch_r.hit_valid <= 1'b0;
            launch_r.free      <= 1'b0;
            launch_r.free_idx  <= '0;
            launch_r.tgt_zero  <= 1'b1;
            state_r            <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (chain[NUM_SLOTS].vld) begin
            fin_r   <= chain[NUM_SLOTS];
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_slot_r      <= res_slot;
            out_must_read_r <= res_rd;
            out_status_r    <= res_st;
            state_r         <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_slot      = out_slot_r;
  assign out_must_read = out_must_read_r;
  assign out_status    = out_status_r;

endmodule

@@ sv/bct_cell.sv @@
// One slot of the tag table: holds its tag and count, and passes the request token on.
module bct_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  bct_pkg::bct_tok_t tok_i,
  output bct_pkg::bct_tok_t tok_o,
  input  bct_pkg::bct_cmt_t cmt_i
);
  import bct_pkg::*;

  localparam logic [BCT_IDX_W-1:0] MY_IDX = BCT_IDX_W'(CELL_IDX);

  logic [7:0]            dev_r, dev_nxt;
  logic [31:0]           blk_r, blk_nxt;
  logic [BCT_REFS_W-1:0] refs_r, refs_nxt;
  logic                  valid_r, valid_nxt;
  logic                  assigned_r, assigned_nxt;
  bct_tok_t              tok_r, tok_nxt;
  logic                  mine;
  logic [BCT_REFS_W-1:0] refs_inc;

  assign mine     = cmt_i.vld && (cmt_i.idx == MY_IDX);
  assign refs_inc = (refs_r == BCT_REFS_MAX) ? refs_r : refs_r + 1'b1;

  always_comb begin
    dev_nxt      = dev_r;
    blk_nxt      = blk_r;
    refs_nxt     = refs_r;
    valid_nxt    = valid_r;
    assigned_nxt = assigned_r;
    if (mine) begin
      unique case (cmt_i.kind)
        CMT_HIT: begin
          refs_nxt  = refs_inc;
          valid_nxt = 1'b1;
        end
        CMT_CLAIM: begin
          dev_nxt      = cmt_i.dev;
          blk_nxt      = cmt_i.blk;
          refs_nxt     = BCT_REFS_W'(1);
          valid_nxt    = 1'b1;
          assigned_nxt = 1'b1;
        end
        CMT_INC: refs_nxt = refs_inc;
        CMT_DEC: refs_nxt = refs_r - 1'b1;
        default: refs_nxt = refs_r;
      endcase
    end
  end

  always_comb begin
    tok_nxt = tok_i;
    if (tok_i.vld) begin
      if (!tok_i.hit && assigned_r && (dev_r == tok_i.dev) && (blk_r == tok_i.blk)) begin
        tok_nxt.hit       = 1'b1;
        tok_nxt.hit_idx   = MY_IDX;
        tok_nxt.hit_valid = valid_r;
      end
      if (!tok_i.free && (refs_r == '0)) begin
        tok_nxt.free     = 1'b1;
        tok_nxt.free_idx = MY_IDX;
      end
      if (BCT_IDX_W'(tok_i.bslot) == MY_IDX) begin
        tok_nxt.tgt_zero = (refs_r == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refs_r     <= '0;
      valid_r    <= 1'b0;
      assigned_r <= 1'b0;
      tok_r      <= '0;
    end else begin
      refs_r     <= refs_nxt;
      valid_r    <= valid_nxt;
      assigned_r <= assigned_nxt;
      tok_r      <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dev_r <= dev_nxt;
    blk_r <= blk_nxt;
  end

  assign tok_o = tok_r;

endmodule

@@ sv/bct_check.sv @@
// Port-level checks of the buffer cache tag table, bound to the top level.
module bct_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  out_slot,
  input logic        out_must_read,
  input logic [1:0]  out_status
);
  import bct_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot) && $stable(out_status))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while a request is in flight");

  a_read_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_must_read |-> out_status == ST_OK)
    else $error("read flagged on a failed request");

  a_nofree_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NOFREE |-> out_slot == '0 && !out_must_read)
    else $error("no-free result carries a slot");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_NOFREE || out_status == ST_UNDER)
    else $error("undefined status code");

endmodule

bind block_buffer_cache_tags bct_check u_bct_check (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_slot     (out_slot),
  .out_must_read(out_must_read),
  .out_status   (out_status)
);
